### rtl/hsv_pkg.sv
package hsv_pkg;

  // Field and internal widths
  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned RemW  = 6;   // remainder within a 60 degree sector
  localparam int unsigned QuoW  = 4;   // hue / 60, up to 8 for a 9-bit hue
  localparam int unsigned TermW = 13;  // sat-scaled terms, up to 6000
  localparam int unsigned NumW  = 20;  // numerators over 600000, up to 600000
  localparam int unsigned ChanW = 8;

  localparam int unsigned PctFull   = 100;
  localparam int unsigned DegSector = 60;
  localparam int unsigned Sectors   = 6;
  localparam int unsigned FullScale = PctFull * DegSector;  // 6000

  // hue / 60 as (hue * 1093) >> 16; exact for hue < 512
  localparam int unsigned HueRecip = 1093;
  localparam int unsigned HueShift = 16;

  // num * 255 / 600000 == num * 17 / 40000
  // == (num * 17 * ceil(2^39 / 40000)) >> 39, exact for num <= 600000
  localparam int unsigned ScaleMul   = 233646232;
  localparam int unsigned ScaleMulW  = 28;
  localparam int unsigned ScaleShift = 39;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t             sector;
    logic [RemW-1:0]     rem;
    logic [PctW-1:0]     sat;
    logic [PctW-1:0]     val;
  } hue_split_t;

  typedef struct packed {
    sector_t             sector;
    logic [PctW-1:0]     val;
    logic [TermW-1:0]    pterm;
    logic [TermW-1:0]    qterm;
    logic [TermW-1:0]    tterm;
  } sat_terms_t;

  typedef struct packed {
    logic [NumW-1:0]     red;
    logic [NumW-1:0]     green;
    logic [NumW-1:0]     blue;
  } rgb_num_t;

  typedef struct packed {
    logic [ChanW-1:0]    red;
    logic [ChanW-1:0]    green;
    logic [ChanW-1:0]    blue;
  } rgb_t;

endpackage

### rtl/hsv_sector.sv
// Stage 1: clamp sat/val, split hue into sector and remainder.
module hsv_sector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsv_pkg::HueW-1:0]    hue,
  input  logic [hsv_pkg::PctW-1:0]    sat,
  input  logic [hsv_pkg::PctW-1:0]    val,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hsv_pkg::hue_split_t         out_data
);

  localparam int HueW = hsv_pkg::HueW;
  localparam int PctW = hsv_pkg::PctW;
  localparam int RemW = hsv_pkg::RemW;
  localparam int QuoW = hsv_pkg::QuoW;
  localparam int ProdW = hsv_pkg::HueShift + QuoW;

  logic                 valid_r;
  hsv_pkg::hue_split_t  data_r;
  hsv_pkg::hue_split_t  data_nxt;
  logic [ProdW-1:0]     hue_prod;
  logic [QuoW-1:0]      quo;
  logic [HueW-1:0]      base;
  logic [PctW-1:0]      sat_c;
  logic [PctW-1:0]      val_c;

  assign hue_prod = ProdW'(hue) * ProdW'(hsv_pkg::HueRecip);
  assign quo      = hue_prod[hsv_pkg::HueShift +: QuoW];
  assign base     = HueW'(32'(quo) * hsv_pkg::DegSector);
  assign sat_c    = (sat > PctW'(hsv_pkg::PctFull)) ? PctW'(hsv_pkg::PctFull) : sat;
  assign val_c    = (val > PctW'(hsv_pkg::PctFull)) ? PctW'(hsv_pkg::PctFull) : val;

  always_comb begin
    data_nxt.rem = RemW'(hue - base);
    data_nxt.sat = sat_c;
    data_nxt.val = val_c;
    // quotient tops out at 8, so one subtract wraps it
    if (32'(quo) >= hsv_pkg::Sectors) begin
      data_nxt.sector = hsv_pkg::sector_t'(3'(32'(quo) - hsv_pkg::Sectors));
    end else begin
      data_nxt.sector = hsv_pkg::sector_t'(3'(quo));
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/hsv_terms.sv
// Stage 2: saturation-scaled terms for p, q and t (numerators over 6000).
module hsv_terms (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsv_pkg::hue_split_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv_pkg::sat_terms_t   out_data
);

  localparam int TermW = hsv_pkg::TermW;
  localparam int PctW  = hsv_pkg::PctW;

  logic                 valid_r;
  hsv_pkg::sat_terms_t  data_r;
  hsv_pkg::sat_terms_t  data_nxt;
  logic [TermW-1:0]     rem_sat;
  logic [TermW-1:0]     crem_sat;
  logic [TermW-1:0]     crem;

  assign rem_sat  = TermW'(in_data.rem) * TermW'(in_data.sat);
  assign crem     = TermW'(hsv_pkg::DegSector) - TermW'(in_data.rem);
  assign crem_sat = crem * TermW'(in_data.sat);

  always_comb begin
    data_nxt.sector = in_data.sector;
    data_nxt.val    = in_data.val;
    data_nxt.pterm  = TermW'(PctW'(hsv_pkg::PctFull) - in_data.sat)
                      * TermW'(hsv_pkg::DegSector);
    data_nxt.qterm  = TermW'(hsv_pkg::FullScale) - rem_sat;
    data_nxt.tterm  = TermW'(hsv_pkg::FullScale) - crem_sat;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/hsv_mix.sv
// Stage 3: scale by value, then route V/p/q/t to r/g/b per sector.
module hsv_mix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsv_pkg::sat_terms_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv_pkg::rgb_num_t     out_data
);

  localparam int NumW = hsv_pkg::NumW;

  logic               valid_r;
  hsv_pkg::rgb_num_t  data_r;
  hsv_pkg::rgb_num_t  data_nxt;
  logic [NumW-1:0]    vv;
  logic [NumW-1:0]    pp;
  logic [NumW-1:0]    qq;
  logic [NumW-1:0]    tt;

  assign vv = NumW'(in_data.val) * NumW'(hsv_pkg::FullScale);
  assign pp = NumW'(in_data.val) * NumW'(in_data.pterm);
  assign qq = NumW'(in_data.val) * NumW'(in_data.qterm);
  assign tt = NumW'(in_data.val) * NumW'(in_data.tterm);

  always_comb begin
    case (in_data.sector)
      hsv_pkg::SEC_R_TO_Y: begin
        data_nxt = '{red: vv, green: tt, blue: pp};
      end
      hsv_pkg::SEC_Y_TO_G: begin
        data_nxt = '{red: qq, green: vv, blue: pp};
      end
      hsv_pkg::SEC_G_TO_C: begin
        data_nxt = '{red: pp, green: vv, blue: tt};
      end
      hsv_pkg::SEC_C_TO_B: begin
        data_nxt = '{red: pp, green: qq, blue: vv};
      end
      hsv_pkg::SEC_B_TO_M: begin
        data_nxt = '{red: tt, green: pp, blue: vv};
      end
      default: begin
        data_nxt = '{red: vv, green: pp, blue: qq};
      end
    endcase
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/hsv_scale.sv
// Stage 4: floor(num * 255 / 600000) by reciprocal multiply; output register.
module hsv_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsv_pkg::rgb_num_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv_pkg::rgb_t         out_data
);

  localparam int NumW  = hsv_pkg::NumW;
  localparam int ChanW = hsv_pkg::ChanW;
  localparam int ProdW = hsv_pkg::NumW + hsv_pkg::ScaleMulW;

  logic           valid_r;
  hsv_pkg::rgb_t  data_r;
  hsv_pkg::rgb_t  data_nxt;

  function automatic logic [ChanW-1:0] to_chan(input logic [NumW-1:0] num);
    logic [ProdW-1:0] prod;
    prod = ProdW'(num) * ProdW'(hsv_pkg::ScaleMul);
    return prod[hsv_pkg::ScaleShift +: ChanW];
  endfunction

  always_comb begin
    data_nxt.red   = to_chan(in_data.red);
    data_nxt.green = to_chan(in_data.green);
    data_nxt.blue  = to_chan(in_data.blue);
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/hsv_to_rgb_converter.sv
// HSV to RGB color converter, exact integer arithmetic.
//
// Input channel (in_valid/in_ready): one transaction per pixel carrying hue in
// whole degrees (360 and above wrap by 360), saturation and value in whole
// percent (above 100 clamps to 100).
// Output channel (out_valid/out_ready): one transaction per input with 8-bit
// red, green and blue, each floor(exact channel value * 255).
//
// Each accepted pixel passes through four register stages (hue split,
// saturation terms, value multiply and sector routing, scale to 8 bits),
// each holding one transaction. Throughput is one pixel per clock while
// the output is not stalled.
//
// Reset (rst_n low, synchronous) empties every stage; no transaction is
// presented afterwards until a new one is accepted.
// When the receiver drops out_ready the result holds in the output register.
// Each stage keeps taking data while it or the stage after it has room, so
// bubbles close up; in_ready falls only once all four stages are full.
module hsv_to_rgb_converter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hsv_pkg::HueW-1:0]  in_hue_deg,
  input  logic [hsv_pkg::PctW-1:0]  in_sat_pct,
  input  logic [hsv_pkg::PctW-1:0]  in_val_pct,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hsv_pkg::ChanW-1:0] out_red,
  output logic [hsv_pkg::ChanW-1:0] out_green,
  output logic [hsv_pkg::ChanW-1:0] out_blue
);

  // stage-to-stage handshake
  logic                 s1_valid, s1_ready;
  logic                 s2_valid, s2_ready;
  logic                 s3_valid, s3_ready;
  hsv_pkg::hue_split_t  s1_data;
  hsv_pkg::sat_terms_t  s2_data;
  hsv_pkg::rgb_num_t    s3_data;
  hsv_pkg::rgb_t        s4_data;

  // sector = floor(hue/60) mod 6, rem = hue mod 60
  hsv_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hue       (in_hue_deg),
    .sat       (in_sat_pct),
    .val       (in_val_pct),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // p, q, t before value scaling, over 6000
  hsv_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // numerators over 600000, routed by sector
  hsv_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // truncated 8-bit channels; this stage is the output register
  hsv_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (s4_data)
  );

  assign out_red   = s4_data.red;
  assign out_green = s4_data.green;
  assign out_blue  = s4_data.blue;

endmodule

### rtl/hsv_checker.sv
module hsv_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [hsv_pkg::HueW-1:0]  in_hue_deg,
  input logic [hsv_pkg::PctW-1:0]  in_sat_pct,
  input logic [hsv_pkg::PctW-1:0]  in_val_pct,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hsv_pkg::ChanW-1:0] out_red,
  input logic [hsv_pkg::ChanW-1:0] out_green,
  input logic [hsv_pkg::ChanW-1:0] out_blue
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red)
      && $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed or dropped");

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_hue_deg)
      && $stable(in_sat_pct) && $stable(in_val_pct))
    else $error("waiting input changed or dropped");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // an empty output stage frees the whole pipe
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // a draining receiver never backs up the input
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the HSV to RGB pixel converter.
// A directed table runs first, then ~750 random pixels. Every accepted output
// transaction is compared field by field against the oldest pending pixel.
module tb_top;
  import hsv_pkg::*;

  localparam int unsigned ChanMax   = 255;
  localparam int unsigned ColorDen  = PctFull * FullScale;  // 600000
  localparam int unsigned RandCount = 750;
  localparam int unsigned CalmTail  = 100;  // last random pixels run with no idling

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [HueW-1:0]    in_hue_deg;
  logic [PctW-1:0]    in_sat_pct;
  logic [PctW-1:0]    in_val_pct;
  logic               out_valid;
  logic               out_ready;
  logic [ChanW-1:0]   out_red;
  logic [ChanW-1:0]   out_green;
  logic [ChanW-1:0]   out_blue;

  // One row of the directed table. Rows with color_known carry a hand-typed
  // color; the rest get theirs from the predictor.
  typedef struct {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
    bit              color_known;
    rgb_t            color;
  } pixel_row_t;

  pixel_row_t  pixel_table[$];
  rgb_t        pending_rgb[$];   // colors of accepted pixels not yet seen at the output
  rgb_t        in_color;         // color expected for the pixel now on the input
  rgb_t        got_rgb;
  rgb_t        want_rgb;
  int unsigned pixels_taken;
  int unsigned mismatches;
  bit          send_gaps;        // sender idles in bursts while set
  bit          calm_tail;        // final stretch: nobody idles

  hsv_to_rgb_converter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_hue_deg (in_hue_deg),
    .in_sat_pct (in_sat_pct),
    .in_val_pct (in_val_pct),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact HSV -> RGB: every component is a numerator over 600000, then
  // scaled by 255 and truncated. Hue wraps by 360, sat/val clamp at 100.
  function automatic rgb_t hsv_to_rgb(input logic [HueW-1:0] hue,
                                      input logic [PctW-1:0] sat,
                                      input logic [PctW-1:0] val);
    int unsigned     s;
    int unsigned     v;
    int unsigned     rem;
    logic [2:0]      sec;
    longint unsigned v_num;
    longint unsigned p_num;
    longint unsigned q_num;
    longint unsigned t_num;
    longint unsigned r_num;
    longint unsigned g_num;
    longint unsigned b_num;
    rgb_t            c;
    s     = (sat > PctFull) ? PctFull : sat;
    v     = (val > PctFull) ? PctFull : val;
    sec   = 3'((hue / DegSector) % Sectors);
    rem   = hue % DegSector;
    v_num = v * FullScale;
    p_num = v * (PctFull - s) * DegSector;
    q_num = v * (FullScale - rem * s);
    t_num = v * (FullScale - (DegSector - rem) * s);
    case (sector_t'(sec))
      SEC_R_TO_Y: begin r_num = v_num; g_num = t_num; b_num = p_num; end
      SEC_Y_TO_G: begin r_num = q_num; g_num = v_num; b_num = p_num; end
      SEC_G_TO_C: begin r_num = p_num; g_num = v_num; b_num = t_num; end
      SEC_C_TO_B: begin r_num = p_num; g_num = q_num; b_num = v_num; end
      SEC_B_TO_M: begin r_num = t_num; g_num = p_num; b_num = v_num; end
      default: begin r_num = v_num; g_num = p_num; b_num = q_num; end
    endcase
    c.red   = ChanW'(r_num * ChanMax / ColorDen);
    c.green = ChanW'(g_num * ChanMax / ColorDen);
    c.blue  = ChanW'(b_num * ChanMax / ColorDen);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic add_row(input int unsigned hue, input int unsigned sat,
                         input int unsigned val, input bit known,
                         input int unsigned r, input int unsigned g,
                         input int unsigned b);
    pixel_row_t row;
    row.hue         = HueW'(hue);
    row.sat         = PctW'(sat);
    row.val         = PctW'(val);
    row.color_known = known;
    row.color       = '{red: ChanW'(r), green: ChanW'(g), blue: ChanW'(b)};
    pixel_table.push_back(row);
  endtask

  // Called at a falling edge. Optionally idles, then presents the pixel and
  // holds it until the monitor has counted the handshake. in_valid is left
  // high so back-to-back transactions need no drop.
  task automatic send_pixel(input logic [HueW-1:0] hue, input logic [PctW-1:0] sat,
                            input logic [PctW-1:0] val, input rgb_t color);
    int unsigned taken_before;
    if (send_gaps && !calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_hue_deg   = hue;
    in_sat_pct   = sat;
    in_val_pct   = val;
    in_color     = color;
    in_valid     = 1'b1;
    taken_before = pixels_taken;
    do @(negedge clk); while (pixels_taken == taken_before);
  endtask

  task automatic wait_drained();
    while (pending_rgb.size() != 0) @(negedge clk);
  endtask

  // Monitor: sampled at the rising edge, before any flop in the DUT updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_rgb.push_back(in_color);
        pixels_taken++;
      end
      if (out_valid && out_ready) begin
        got_rgb = '{red: out_red, green: out_green, blue: out_blue};
        if (pending_rgb.size() == 0) begin
          report_mismatch($sformatf("output rgb=(%0d,%0d,%0d) with no pixel pending",
                                    got_rgb.red, got_rgb.green, got_rgb.blue));
        end else begin
          want_rgb = pending_rgb.pop_front();
          if (got_rgb.red !== want_rgb.red)
            report_mismatch($sformatf("red got %0d want %0d", got_rgb.red, want_rgb.red));
          if (got_rgb.green !== want_rgb.green)
            report_mismatch($sformatf("green got %0d want %0d",
                                      got_rgb.green, want_rgb.green));
          if (got_rgb.blue !== want_rgb.blue)
            report_mismatch($sformatf("blue got %0d want %0d",
                                      got_rgb.blue, want_rgb.blue));
        end
      end
    end
  end

  // Receiver backpressure: stall bursts of random length between ready
  // stretches of random length; none during the calm tail.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm_tail && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(0, 30)) @(negedge clk);
    end
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Main stimulus
  initial begin
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
    rgb_t            color;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_hue_deg   = '0;
    in_sat_pct   = '0;
    in_val_pct   = '0;
    in_color     = '0;
    pixels_taken = 0;
    mismatches   = 0;
    send_gaps    = 1'b1;
    calm_tail    = 1'b0;

    // Primaries and secondaries at each sector start, wrap, clamps, black/white
    add_row(  0, 100, 100, 1, 255,   0,   0);
    add_row( 60, 100, 100, 1, 255, 255,   0);
    add_row(120, 100, 100, 1,   0, 255,   0);
    add_row(180, 100, 100, 1,   0, 255, 255);
    add_row(240, 100, 100, 1,   0,   0, 255);
    add_row(300, 100, 100, 1, 255,   0, 255);
    add_row(360, 100, 100, 1, 255,   0,   0);  // 360 wraps to 0
    add_row(  0,   0,   0, 1,   0,   0,   0);
    add_row(200,   0, 100, 1, 255, 255, 255);  // no saturation -> gray at V
    add_row( 45,   0, 127, 1, 255, 255, 255);  // value clamps to 100
    add_row(  0, 127,   0, 1,   0,   0,   0);
    add_row(511, 127, 127, 1,   0, 255, 131);  // top hue wraps, both clamp
    add_row(359, 100, 100, 0, 0, 0, 0);
    add_row( 59, 100, 100, 0, 0, 0, 0);
    add_row( 61,  50,  75, 0, 0, 0, 0);
    add_row(361, 100, 100, 0, 0, 0, 0);
    add_row(420,  80,  90, 0, 0, 0, 0);
    add_row(480, 100, 100, 0, 0, 0, 0);
    add_row( 30, 101, 100, 0, 0, 0, 0);  // sat just over full scale
    add_row( 90, 100, 101, 0, 0, 0, 0);
    add_row(  1,   1,   1, 0, 0, 0, 0);
    add_row(256,  64,  64, 0, 0, 0, 0);
    add_row(150, 100,  50, 0, 0, 0, 0);
    add_row(330, 127,  33, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (pixel_table[i]) begin
      color = pixel_table[i].color_known ? pixel_table[i].color :
              hsv_to_rgb(pixel_table[i].hue, pixel_table[i].sat, pixel_table[i].val);
      send_pixel(pixel_table[i].hue, pixel_table[i].sat, pixel_table[i].val, color);
    end

    // Let the pipe run dry before random traffic
    in_valid = 1'b0;
    wait_drained();

    for (int unsigned n = 0; n < RandCount; n++) begin
      // Sender idling comes and goes in stretches of 50 transactions
      if (n % 50 == 0) send_gaps = ($urandom_range(0, 2) != 0);
      if (n == RandCount - CalmTail) calm_tail = 1'b1;
      // Mid-run: hold off until the pipe has fully emptied
      if (n == RandCount / 2) begin
        in_valid = 1'b0;
        wait_drained();
      end
      // Mostly legal HSV; the rest spans every encodable value
      if ($urandom_range(0, 6) != 0) begin
        hue = HueW'($urandom_range(0, 360));
        sat = PctW'($urandom_range(0, PctFull));
        val = PctW'($urandom_range(0, PctFull));
      end else begin
        hue = HueW'($urandom_range(0, (1 << HueW) - 1));
        sat = PctW'($urandom_range(0, (1 << PctW) - 1));
        val = PctW'($urandom_range(0, (1 << PctW) - 1));
      end
      send_pixel(hue, sat, val, hsv_to_rgb(hue, sat, val));
    end

    in_valid = 1'b0;
    wait_drained();
    // Idle on to catch any stray output past the pipeline depth
    repeat (12) @(negedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
